### design/qcfir_pkg.sv
`timescale 1ns / 1ps

package qcfir_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 18;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int FRAC_BITS   = 17;
   localparam int TAP_INDEX_W = 6;
   localparam int TAP_COUNT_W = 7;
   localparam int IO_CHANNELS = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

   // command codes
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // register word index
   localparam logic REG_TAP_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } qcfir_state_type;

   typedef struct packed {
      logic                   shift;
      logic                   rotate;
      logic                   load;
      logic [TAP_INDEX_W-1:0] load_index;
   } qcfir_cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic use_tap;
   } qcfir_mac_ctrl_type;

endpackage

### design/qcfir_if.sv
`timescale 1ns / 1ps

interface qcfir_req_if;
   import qcfir_pkg::*;
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic        [TAP_INDEX_W-1:0]     tap_index;
   logic signed [SAMPLE_W-1:0]        value_a;
   logic signed [SAMPLE_W-1:0]        value_b;
   logic signed [SAMPLE_W-1:0]        value_c;
   logic signed [SAMPLE_W-1:0]        value_d;

   modport source (output valid, command, tap_index, value_a, value_b, value_c, value_d,
                   input ready);
   modport sink (input valid, command, tap_index, value_a, value_b, value_c, value_d,
                 output ready);
endinterface

interface qcfir_rsp_if;
   import qcfir_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_a;
   logic signed [SAMPLE_W-1:0] out_b;
   logic signed [SAMPLE_W-1:0] out_c;
   logic signed [SAMPLE_W-1:0] out_d;

   modport source (output valid, out_a, out_b, out_c, out_d, input ready);
   modport sink (input valid, out_a, out_b, out_c, out_d, output ready);
endinterface

### design/quad_channel_overlap_add_fir.sv
`timescale 1ns / 1ps
// A sample beat turns the tap ring once past the per-channel MAC in ST_RUN, then
// passes ST_DRAIN and ST_FINISH (held while a result is unaccepted) to the output
// register; no new beat is taken until then. A tap load beat is absorbed in the
// cycle it is accepted and yields nothing; one tap load per cycle while idle.
// Reset (synchronous, active high) zeroes all taps and history, sets tap_count to 64.
module quad_channel_overlap_add_fir import qcfir_pkg::*; #(
   parameter int TAPS     = 64,
   parameter int CHANNELS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   qcfir_req_if.sink             req_port,
   qcfir_rsp_if.source           rsp_port,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // Step counter walks the ring; effective tap count needs to hold TAPS itself.
   localparam int STEP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W  = $clog2(TAPS + 1);
   localparam int CMP_W  = (CNT_W > TAP_COUNT_W) ? CNT_W : TAP_COUNT_W;

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [TAP_COUNT_W-1:0] tap_count_ff;
   logic [TAP_COUNT_W-1:0] tap_count_in;
   logic                   csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      tap_count_in = tap_count_ff;
      if (csr_write && (csr_paddr[2] == REG_TAP_COUNT)) begin
         tap_count_in = csr_pwdata[TAP_COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_TAP_COUNT) begin
         csr_prdata = CSR_DATA_W'(tap_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   qcfir_state_type      state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]     m_ff, m_in;
   logic [CMP_W-1:0]     tc_wide;
   logic                 req_accept;
   logic                 finish_load;
   logic                 rsp_valid_ff, rsp_valid_in;
   qcfir_cell_ctrl_type  cell_ctrl;
   qcfir_mac_ctrl_type   mac_ctrl;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;

   // tap_count of zero acts as one, above TAPS acts as TAPS
   always_comb begin
      tc_wide = CMP_W'(tap_count_ff);
      if (tc_wide == '0) begin
         m_in = CNT_W'(1);
      end else if (tc_wide > CMP_W'(TAPS)) begin
         m_in = CNT_W'(TAPS);
      end else begin
         m_in = tc_wide[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = '0;
      finish_load  = 1'b0;
      cell_ctrl    = '0;
      mac_ctrl     = '0;
      cell_ctrl.load_index = req_port.tap_index;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_port.command == CMD_SAMPLE) begin
                  cell_ctrl.shift = 1'b1;
                  mac_ctrl.clear  = 1'b1;
                  state_in        = ST_RUN;
               end else begin
                  cell_ctrl.load = 1'b1;
               end
            end
         end
         ST_RUN: begin
            // ring head holds tap step_ff; a full turn restores the ring
            cell_ctrl.rotate = 1'b1;
            mac_ctrl.use_tap = (CNT_W'(step_ff) < m_ff);
            step_in          = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(TAPS - 1)) begin
               step_in  = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               finish_load = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         m_ff     <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (req_accept && (req_port.command == CMD_SAMPLE)) begin
            m_ff <= m_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Input lanes: channels past D see zero samples and zero taps
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] req_values [IO_CHANNELS];
   logic signed [SAMPLE_W-1:0] new_sample [CHANNELS];
   logic signed [COEF_W-1:0]   new_coef   [CHANNELS];

   assign req_values[0] = req_port.value_a;
   assign req_values[1] = req_port.value_b;
   assign req_values[2] = req_port.value_c;
   assign req_values[3] = req_port.value_d;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      if (c < IO_CHANNELS) begin : g_io
         assign new_sample[c] = req_values[c];
         assign new_coef[c]   = req_values[c][COEF_W-1:0];
      end else begin : g_zero
         assign new_sample[c] = '0;
         assign new_coef[c]   = '0;
      end
   end

   // ------------------------------------------------------------------
   // Tap ring: shift pushes history toward higher index, rotate moves
   // every cell one place toward cell 0 with wrap-around
   // ------------------------------------------------------------------
   logic signed [COEF_W-1:0]   coef_w   [TAPS][CHANNELS];
   logic signed [SAMPLE_W-1:0] sample_w [TAPS][CHANNELS];

   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      logic signed [SAMPLE_W-1:0] shift_src [CHANNELS];
      if (k == 0) begin : g_head
         assign shift_src = new_sample;
      end else begin : g_body
         assign shift_src = sample_w[k-1];
      end

      qcfir_cell #(
         .CHANNELS (CHANNELS),
         .IDX      (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .shift_sample (shift_src),
         .ring_sample  (sample_w[(k + 1) % TAPS]),
         .ring_coef    (coef_w[(k + 1) % TAPS]),
         .load_coef    (new_coef),
         .coef_out     (coef_w[k]),
         .sample_out   (sample_w[k])
      );
   end

   // ------------------------------------------------------------------
   // One MAC per channel at the ring head
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] mac_result [CHANNELS];

   for (genvar c = 0; c < CHANNELS; c++) begin : g_mac
      qcfir_mac #(
         .TAPS (TAPS)
      ) u_mac (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (mac_ctrl),
         .coef   (coef_w[0][c]),
         .sample (sample_w[0][c]),
         .result (mac_result[c])
      );
   end

   // ------------------------------------------------------------------
   // Output register: holds a finished beat while the next item runs
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] out_ff [IO_CHANNELS];

   assign rsp_valid_in = finish_load || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar c = 0; c < IO_CHANNELS; c++) begin : g_out
      always_ff @(posedge clock) begin
         if (finish_load) begin
            if (c < CHANNELS) begin
               out_ff[c] <= mac_result[c % CHANNELS];
            end else begin
               out_ff[c] <= '0;   // missing channel reads zero
            end
         end
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.out_a = out_ff[0];
   assign rsp_port.out_b = out_ff[1];
   assign rsp_port.out_c = out_ff[2];
   assign rsp_port.out_d = out_ff[3];

endmodule

### design/qcfir_cell.sv
`timescale 1ns / 1ps

// One tap position of the ring: a coefficient and a history sample per channel.
module qcfir_cell import qcfir_pkg::*; #(
   parameter int CHANNELS = 4,
   parameter int IDX      = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  qcfir_cell_ctrl_type        ctrl,
   input  logic signed [SAMPLE_W-1:0] shift_sample [CHANNELS],
   input  logic signed [SAMPLE_W-1:0] ring_sample  [CHANNELS],
   input  logic signed [COEF_W-1:0]   ring_coef    [CHANNELS],
   input  logic signed [COEF_W-1:0]   load_coef    [CHANNELS],
   output logic signed [COEF_W-1:0]   coef_out     [CHANNELS],
   output logic signed [SAMPLE_W-1:0] sample_out   [CHANNELS]
);

   localparam bit REACHABLE = (IDX < (1 << TAP_INDEX_W));

   logic signed [COEF_W-1:0]   coef_ff   [CHANNELS];
   logic signed [COEF_W-1:0]   coef_in   [CHANNELS];
   logic signed [SAMPLE_W-1:0] sample_ff [CHANNELS];
   logic signed [SAMPLE_W-1:0] sample_in [CHANNELS];
   logic                       hit;

   assign hit = REACHABLE && (ctrl.load_index == TAP_INDEX_W'(IDX));

   always_comb begin
      coef_in   = coef_ff;
      sample_in = sample_ff;
      if (ctrl.rotate) begin
         coef_in   = ring_coef;
         sample_in = ring_sample;
      end else begin
         if (ctrl.shift) begin
            sample_in = shift_sample;
         end
         if (ctrl.load && hit) begin
            coef_in = load_coef;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            coef_ff[c]   <= '0;
            sample_ff[c] <= '0;
         end
      end else begin
         coef_ff   <= coef_in;
         sample_ff <= sample_in;
      end
   end

   assign coef_out   = coef_ff;
   assign sample_out = sample_ff;

endmodule

### design/qcfir_mac.sv
`timescale 1ns / 1ps

// Per-channel multiply-accumulate at the ring head, with Q1.17 rounding and clamp.
module qcfir_mac import qcfir_pkg::*; #(
   parameter int TAPS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  qcfir_mac_ctrl_type         ctrl,
   input  logic signed [COEF_W-1:0]   coef,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [SAMPLE_W-1:0] result
);

   localparam int ACC_W = PROD_W + $clog2(TAPS + 1) + 1;
   localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     use_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [ACC_W-1:0]  scaled;

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (use_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff <= 1'b0;
      end else begin
         use_ff <= ctrl.use_tap;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= coef * sample;
      acc_ff  <= acc_in;
   end

   // floor((acc + 2^16) / 2^17), then clamp to 24 bits
   assign rounded = acc_ff + HALF;
   assign scaled  = rounded >>> FRAC_BITS;

   always_comb begin
      if (scaled > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_W-1:0];
      end else if (scaled < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         result = scaled[SAMPLE_W-1:0];
      end
   end

endmodule

### tb/tb_quad_channel_overlap_add_fir.sv
`timescale 1ns / 1ps

module tb_quad_channel_overlap_add_fir import qcfir_pkg::*; ();

   localparam int TAPS     = 64;
   localparam int CHANNELS = 4;

   // a sample beat's full pass through the block, plus a drain margin on top
   localparam int DRAIN_CYCLES     = TAPS + 8;
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int LONG_HOLD_CYCLES = 1500;
   localparam int NUM_PHASES       = 9;
   localparam int PHASE_BEATS      = 136;
   localparam int JUNK_W           = SAMPLE_W - COEF_W;

   // register map: word i at byte 4*i
   localparam logic [CSR_ADDR_W-1:0] TAP_COUNT_ADDR  = CSR_ADDR_W'({REG_TAP_COUNT, 2'b00});
   localparam logic [CSR_ADDR_W-1:0] UNUSED_REG_ADDR = CSR_ADDR_W'(4);

   typedef struct {
      logic                       command;
      logic [TAP_INDEX_W-1:0]     tap_index;
      logic signed [SAMPLE_W-1:0] value [IO_CHANNELS];
   } fir_beat_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] ch [IO_CHANNELS];
   } fir_output_type;

   // Scoreboard: keeps its own copy of taps, delay lines and tap_count,
   // predicts each filtered output and checks result beats in order.
   class fir_scoreboard;
      localparam int     TAP_N      = TAPS;
      localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
      localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

      logic signed [COEF_W-1:0]   taps    [IO_CHANNELS][TAP_N];
      logic signed [SAMPLE_W-1:0] history [IO_CHANNELS][TAP_N];
      logic [TAP_COUNT_W-1:0]     tap_count;
      fir_output_type             expected_outputs [$];
      int unsigned                mismatches;
      int unsigned                outputs_checked;
      int unsigned                loads_seen;
      int unsigned                samples_seen;

      function new();
         int c, k;
         for (c = 0; c < IO_CHANNELS; c++) begin
            for (k = 0; k < TAP_N; k++) begin
               taps[c][k]    = '0;
               history[c][k] = '0;
            end
         end
         tap_count       = TAP_COUNT_RESET;
         mismatches      = 0;
         outputs_checked = 0;
         loads_seen      = 0;
         samples_seen    = 0;
      endfunction

      function void write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         // only word 0 exists; other words drop the write
         if ((addr >> 2) == CSR_ADDR_W'(REG_TAP_COUNT))
            tap_count = data[TAP_COUNT_W-1:0];
      endfunction

      function logic signed [SAMPLE_W-1:0] clamp_sample(longint v);
         if (v > SAMPLE_MAX)
            return SAMPLE_W'(SAMPLE_MAX);
         if (v < SAMPLE_MIN)
            return SAMPLE_W'(SAMPLE_MIN);
         return SAMPLE_W'(v);
      endfunction

      function void absorb_beat(fir_beat_type b);
         fir_output_type y;
         longint         acc;
         longint         rounded;
         int             used;
         int             c, k;
         if (b.command == CMD_LOAD) begin
            loads_seen++;
            // one tap index writes all channels; upper bits of each word are dropped
            if (int'(b.tap_index) < TAP_N) begin
               for (c = 0; c < IO_CHANNELS; c++)
                  taps[c][b.tap_index] = b.value[c][COEF_W-1:0];
            end
            return;
         end
         samples_seen++;
         used = (tap_count == 0) ? 1 : ((int'(tap_count) > TAP_N) ? TAP_N : int'(tap_count));
         for (c = 0; c < IO_CHANNELS; c++) begin
            for (k = TAP_N - 1; k > 0; k--)
               history[c][k] = history[c][k-1];
            history[c][0] = b.value[c];
            acc = 0;
            for (k = 0; k < used; k++)
               acc += longint'(taps[c][k]) * longint'(history[c][k]);
            // round half up out of Q1.17, then saturate
            rounded = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            y.ch[c] = clamp_sample(rounded);
         end
         expected_outputs.push_back(y);
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("MISMATCH @%0t: %s", $time, what);
      endtask

      task check_output(fir_output_type got);
         fir_output_type want;
         int             c;
         if (expected_outputs.size() == 0) begin
            report_mismatch("result beat with no sample outstanding");
            return;
         end
         want = expected_outputs.pop_front();
         outputs_checked++;
         for (c = 0; c < IO_CHANNELS; c++) begin
            if (got.ch[c] !== want.ch[c])
               report_mismatch($sformatf("result %0d channel %c: got %0d, want %0d",
                                         outputs_checked, 8'(8'd65 + c), got.ch[c], want.ch[c]));
         end
      endtask

      task finish_check();
         if (expected_outputs.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", expected_outputs.size()));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   qcfir_req_if req_bus ();
   qcfir_rsp_if rsp_bus ();

   fir_scoreboard sb = new();

   // sender / receiver idle controls
   bit          sender_calm;
   bit          hold_request;
   int unsigned long_hold_total;

   quad_channel_overlap_add_fir #(
      .TAPS     (TAPS),
      .CHANNELS (CHANNELS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // gap length: mostly none or short, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      else if (pick < 85)
         return $urandom_range(1, 3);
      else if (pick < 96)
         return $urandom_range(4, 16);
      return $urandom_range(40, 160);
   endfunction

   // tap word: junk in the upper bits, Q1.17 tap in the low 18
   function automatic logic [SAMPLE_W-1:0] random_tap_word();
      int unsigned       pick;
      int                t;
      logic [JUNK_W-1:0] junk;
      pick = $urandom_range(0, 99);
      junk = JUNK_W'($urandom);
      if (pick < 45)
         t = int'($urandom_range(0, 1023)) - 512;
      else if (pick < 65)
         t = int'($urandom_range(0, 32767)) - 16384;
      else if (pick < 80)
         t = int'($urandom);
      else if (pick < 90) begin
         case ($urandom_range(0, 3))
            0: t = 'h1FFFF;            // just under +1.0
            1: t = 'h20000;            // -1.0
            2: t = -1;
            default: t = 1;
         endcase
      end else
         t = 0;
      return {junk, COEF_W'(t)};
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int unsigned pick;
      int          t;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         t = int'($urandom);
      else if (pick < 70)
         t = int'($urandom_range(0, 4095)) - 2048;
      else if (pick < 85)
         t = int'($urandom_range(0, 524287)) - 262144;
      else begin
         case ($urandom_range(0, 4))
            0: t = 'h7FFFFF;
            1: t = -'h800000;
            2: t = 0;
            3: t = -1;
            default: t = 1;
         endcase
      end
      return SAMPLE_W'(t);
   endfunction

   function automatic fir_beat_type make_beat(logic cmd, logic [TAP_INDEX_W-1:0] idx,
                                              logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                              logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
      fir_beat_type beat;
      beat.command   = cmd;
      beat.tap_index = idx;
      beat.value[0]  = a;
      beat.value[1]  = b;
      beat.value[2]  = c;
      beat.value[3]  = d;
      return beat;
   endfunction

   // taps_used biases load indexes toward the active part of the filter
   function automatic fir_beat_type random_beat(int taps_used);
      fir_beat_type beat;
      int           c;
      beat.command = ($urandom_range(0, 99) < 35) ? CMD_LOAD : CMD_SAMPLE;
      if ($urandom_range(0, 1) == 1)
         beat.tap_index = TAP_INDEX_W'($urandom_range(0, taps_used - 1));
      else
         beat.tap_index = TAP_INDEX_W'($urandom);
      for (c = 0; c < IO_CHANNELS; c++)
         beat.value[c] = (beat.command == CMD_LOAD) ? random_tap_word() : random_sample();
      return beat;
   endfunction

   // All driving tasks start and end at a falling edge.
   task automatic send_beat(input fir_beat_type beat);
      int unsigned gap;
      req_bus.command   = beat.command;
      req_bus.tap_index = beat.tap_index;
      req_bus.value_a   = beat.value[0];
      req_bus.value_b   = beat.value[1];
      req_bus.value_c   = beat.value[2];
      req_bus.value_d   = beat.value[3];
      req_bus.valid     = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.absorb_beat(beat);
      @(negedge clock);
      gap = sender_calm ? 0 : idle_gap();
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // APB write: setup, then access; lands at the edge with penable && pready
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = addr;
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_register(addr, data);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // wait for outstanding results, then let any tap load in flight settle
   task automatic wait_block_idle();
      while (sb.expected_outputs.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Directed: reset taps give zero, extreme taps and samples drive both
   // saturation rails, channel C keeps only tap 0 = 1 LSB so its outputs hit
   // the round-half-up cases, tap 63 and alternating index bits get loaded,
   // and upper junk in tap words must be dropped.
   task automatic run_directed();
      fir_beat_type seq [$];
      seq.push_back(make_beat(CMD_SAMPLE, 6'h3F, 24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF));
      seq.push_back(make_beat(CMD_LOAD,   6'h00, 24'hFDFFFF, 24'h020000, 24'h000001, 24'hFFFFFF));
      seq.push_back(make_beat(CMD_LOAD,   6'h01, 24'h01FFFF, 24'hFE0000, 24'hFC0000, 24'h01FFFF));
      seq.push_back(make_beat(CMD_LOAD,   6'h02, 24'h01FFFF, 24'h020000, 24'h000000, 24'h000000));
      seq.push_back(make_beat(CMD_LOAD,   6'h3F, 24'h000100, 24'h03FF00, 24'h000000, 24'h020000));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h00, 24'h7FFFFF, 24'h7FFFFF, 24'h010000, 24'h800000));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h15, 24'h7FFFFF, 24'h7FFFFF, 24'hFF0000, 24'h800000));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h2A, 24'h800000, 24'h800000, 24'hFEFFFF, 24'h7FFFFF));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h3F, 24'h800000, 24'h000001, 24'h00FFFF, 24'h000000));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h00, 24'h000000, 24'hFFFFFF, 24'h000000, 24'h555555));
      seq.push_back(make_beat(CMD_LOAD,   6'h15, 24'h2AAAAA, 24'h155555, 24'h000000, 24'h3FFFFF));
      seq.push_back(make_beat(CMD_LOAD,   6'h2A, 24'h155555, 24'h2AAAAA, 24'hFC0000, 24'h000001));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h15, 24'hAAAAAA, 24'h555555, 24'h00FFFF, 24'hAAAAAA));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h2A, 24'h555555, 24'hAAAAAA, 24'hFF0001, 24'h555555));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h00, 24'h000001, 24'hFFFFFF, 24'h010001, 24'h7FFFFF));
      seq.push_back(make_beat(CMD_LOAD,   6'h00, 24'h000000, 24'hFC0000, 24'h000001, 24'h000000));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h3F, 24'h123456, 24'hEDCBA9, 24'hFF0000, 24'h000000));
      seq.push_back(make_beat(CMD_SAMPLE, 6'h00, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000));
      foreach (seq[i])
         send_beat(seq[i]);
   endtask

   // Main sequence: reset, directed beats at the reset tap_count, then one
   // random phase per tap_count setting with a full drain between phases.
   initial begin : stimulus
      fir_beat_type beat;
      int           phase_plan [NUM_PHASES];
      int           taps_used;
      int           p, i;

      reset             = 1'b1;
      sender_calm       = 1'b0;
      hold_request      = 1'b0;
      long_hold_total   = 0;
      req_bus.valid     = 1'b0;
      req_bus.command   = CMD_LOAD;
      req_bus.tap_index = '0;
      req_bus.value_a   = '0;
      req_bus.value_b   = '0;
      req_bus.value_c   = '0;
      req_bus.value_d   = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;

      // 0 acts as 1, anything above TAPS acts as TAPS
      phase_plan = '{1, 0, 127, 64, 2, 65, 33, 0, 0};
      phase_plan[7] = $urandom_range(3, TAPS - 1);
      phase_plan[8] = $urandom_range(TAPS + 2, 126);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      req_bus.valid = 1'b0;
      wait_block_idle();

      for (p = 0; p < NUM_PHASES; p++) begin
         // junk above bit 6 of the write data must be dropped
         csr_write(TAP_COUNT_ADDR,
                   CSR_DATA_W'({$urandom, 7'b0}) | CSR_DATA_W'(phase_plan[p]));
         // a write to a word that does not exist must not touch tap_count
         if (p == 6)
            csr_write(UNUSED_REG_ADDR, $urandom);
         taps_used = (phase_plan[p] == 0) ? 1 : ((phase_plan[p] > TAPS) ? TAPS : phase_plan[p]);
         sender_calm = (p % 3 == 2);
         // receiver backs up the whole pipe once while beats keep coming
         if (p == 1)
            hold_request = 1'b1;
         for (i = 0; i < PHASE_BEATS; i++) begin
            beat = random_beat(taps_used);
            send_beat(beat);
         end
         req_bus.valid = 1'b0;
         wait_block_idle();
      end

      sb.finish_check();
      $display("covered %0d tap loads and %0d sample beats over %0d tap_count settings",
               sb.loads_seen, sb.samples_seen, NUM_PHASES + 1);
      $display("checked %0d result beats; response side stalled %0d cycles in one stretch",
               sb.outputs_checked, long_hold_total);
      if (sb.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Response ready: random stalls, calm stretches keyed off result count,
   // and one long hold-off counted here.
   initial begin : rsp_ready_driver
      int unsigned stall_left;
      bit          calm;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         calm = ((sb.outputs_checked / 40) % 3) == 1;
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold_total = LONG_HOLD_CYCLES;
            hold_request    = 1'b0;
         end else if (stall_left != 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = !reset;
            stall_left    = calm ? 0 : idle_gap();
         end
      end
   end

   // result monitor: every accepted result beat goes to the scoreboard
   always @(posedge clock) begin
      fir_output_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.ch[0] = rsp_bus.out_a;
         got.ch[1] = rsp_bus.out_b;
         got.ch[2] = rsp_bus.out_c;
         got.ch[3] = rsp_bus.out_d;
         sb.check_output(got);
      end
   end

   // watchdog: too many cycles without any handshake ends the run
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
design/qcfir_pkg.sv
design/qcfir_if.sv
design/qcfir_cell.sv
design/qcfir_mac.sv
design/quad_channel_overlap_add_fir.sv
tb/tb_quad_channel_overlap_add_fir.sv
